// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module dptp_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  `ASSERT_CLK(label, clk, rst_n, !(expr))

`endif

// ===== design/dptp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptp_pkg
// Widths, register codes and reset values of the depth pixel to point block.
// ----------------------------------------------------------------------------
package dptp_pkg;

  // Field widths
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned PIX_W    = 10;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned CENTER_W = 14;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned LAT_W    = 21;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 88;
  localparam int unsigned M_USED_W  = 2 * LAT_W + DEPTH_W + COLOR_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_CENTER = 3'd0,
    REG_COL_CENTER = 3'd1,
    REG_INV_ROW_F  = 3'd2,
    REG_INV_COL_F  = 3'd3,
    REG_MAX_DEPTH  = 3'd4,
    REG_COLOR_MODE = 3'd5
  } reg_idx_e;

  // Register reset values
  localparam logic [CENTER_W-1:0] ROW_CENTER_RST = 14'd1906;
  localparam logic [CENTER_W-1:0] COL_CENTER_RST = 14'd3832;
  localparam logic [INV_W-1:0]    INV_FOCAL_RST  = 24'd31957;
  localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST  = 16'd2000;

  localparam logic [COLOR_W-1:0]  COLOR_WHITE    = 24'hFFFFFF;

  // Arithmetic widths: |offset| * Z, then * 1/f, then round and drop 28 bits
  localparam int unsigned OFF_W     = CENTER_W;
  localparam int unsigned PROD1_W   = OFF_W + DEPTH_W;
  localparam int unsigned PROD2_W   = PROD1_W + INV_W;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned MAG_W     = PROD2_W + 1 - FRAC_BITS;

  localparam logic [LAT_W-1:0] LAT_POS_MAX = 21'h0FFFFF;
  localparam logic [LAT_W-1:0] LAT_NEG_MAG = 21'h100000;

endpackage

// ===== design/depth_pixel_to_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Pinhole back-projection of a depth pixel into a 3-D point in millimetres.
// ----------------------------------------------------------------------------
//
//  port group   dir  contents (tdata from bit 0 up)
//  s_axis_*     in   depth_mm[15:0] pixel_row[25:16] pixel_col[35:26]
//                    red[43:36] green[51:44] blue[59:52], zero pad to 64
//  m_axis_*     out  point_x_mm[20:0] point_y_mm[41:21] point_z_mm[57:42]
//                    packed_color[81:58], zero pad to 88
//  cfg_*        in   write enable, register index, write data
//
//  One pixel per clock while m_axis is not stalled. A kept pixel passes
//  the offset stage, the |offset| * Z multiplier, the * 1/f multiplier,
//  and round and saturate into the output register that drives m_axis.
//  Pixels with zero depth or depth above max_depth_mm are accepted and dropped.
//  Each stage holds while the next is full and stalled; empty stages fill in,
//  so a stall on m_axis loses and repeats nothing. Reset clears valid bits
//  and loads the register defaults.
//
module depth_pixel_to_point #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // depth_mm, pixel_row, pixel_col, red, green, blue
  input  logic [dptp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // point results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // point_x_mm, point_y_mm, point_z_mm, packed_color
  output logic [dptp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // register writes
  input  logic                                cfg_we_i,
  input  logic [dptp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dptp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // Coordinate bits that count; the port carries at most PIX_W of them
  localparam int unsigned CW = (COORD_BITS < dptp_pkg::PIX_W) ? COORD_BITS
                                                              : dptp_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [dptp_pkg::CENTER_W-1:0] row_center_q;
  logic [dptp_pkg::CENTER_W-1:0] col_center_q;
  logic [dptp_pkg::INV_W-1:0]    inv_row_q;
  logic [dptp_pkg::INV_W-1:0]    inv_col_q;
  logic [dptp_pkg::DEPTH_W-1:0]  max_depth_q;
  logic                          color_mode_q;

  // Write the addressed register; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_center_q <= dptp_pkg::ROW_CENTER_RST;
      col_center_q <= dptp_pkg::COL_CENTER_RST;
      inv_row_q    <= dptp_pkg::INV_FOCAL_RST;
      inv_col_q    <= dptp_pkg::INV_FOCAL_RST;
      max_depth_q  <= dptp_pkg::MAX_DEPTH_RST;
      color_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dptp_pkg::REG_ROW_CENTER: row_center_q <= cfg_wdata_i[dptp_pkg::CENTER_W-1:0];
        dptp_pkg::REG_COL_CENTER: col_center_q <= cfg_wdata_i[dptp_pkg::CENTER_W-1:0];
        dptp_pkg::REG_INV_ROW_F:  inv_row_q    <= cfg_wdata_i[dptp_pkg::INV_W-1:0];
        dptp_pkg::REG_INV_COL_F:  inv_col_q    <= cfg_wdata_i[dptp_pkg::INV_W-1:0];
        dptp_pkg::REG_MAX_DEPTH:  max_depth_q  <= cfg_wdata_i[dptp_pkg::DEPTH_W-1:0];
        dptp_pkg::REG_COLOR_MODE: color_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage payload types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                           neg_x;
    logic                           neg_y;
    logic [dptp_pkg::OFF_W-1:0]     off_x;
    logic [dptp_pkg::OFF_W-1:0]     off_y;
    logic [dptp_pkg::DEPTH_W-1:0]   z;
    logic [dptp_pkg::COLOR_W-1:0]   color;
  } off_stage_t;

  typedef struct packed {
    logic                           neg_x;
    logic                           neg_y;
    logic [dptp_pkg::PROD1_W-1:0]   prod_x;
    logic [dptp_pkg::PROD1_W-1:0]   prod_y;
    logic [dptp_pkg::DEPTH_W-1:0]   z;
    logic [dptp_pkg::COLOR_W-1:0]   color;
  } mul1_stage_t;

  typedef struct packed {
    logic                           neg_x;
    logic                           neg_y;
    logic [dptp_pkg::PROD2_W-1:0]   prod_x;
    logic [dptp_pkg::PROD2_W-1:0]   prod_y;
    logic [dptp_pkg::DEPTH_W-1:0]   z;
    logic [dptp_pkg::COLOR_W-1:0]   color;
  } mul2_stage_t;

  // Round half away from zero on the magnitude, then saturate and apply sign
  function automatic logic [dptp_pkg::LAT_W-1:0] round_sat(
    input logic [dptp_pkg::PROD2_W-1:0] prod,
    input logic                         neg
  );
    logic [dptp_pkg::PROD2_W:0]      sum;
    logic [dptp_pkg::MAG_W-1:0]      mag;
    logic [dptp_pkg::LAT_W-1:0]      lim;
    sum = {1'b0, prod} + ((dptp_pkg::PROD2_W+1)'(1) << (dptp_pkg::FRAC_BITS - 1));
    mag = sum[dptp_pkg::PROD2_W:dptp_pkg::FRAC_BITS];
    if (neg) begin
      lim = (mag > dptp_pkg::MAG_W'(dptp_pkg::LAT_NEG_MAG)) ? dptp_pkg::LAT_NEG_MAG
                                                          : mag[dptp_pkg::LAT_W-1:0];
      return ~lim + dptp_pkg::LAT_W'(1);
    end else begin
      return (mag > dptp_pkg::MAG_W'(dptp_pkg::LAT_POS_MAX)) ? dptp_pkg::LAT_POS_MAX
                                                           : mag[dptp_pkg::LAT_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake: a stage takes new data when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic        off_vld_q, mul1_vld_q, mul2_vld_q, out_vld_q;
  logic        off_rdy, mul1_rdy, mul2_rdy, out_rdy;

  assign out_rdy       = !out_vld_q  || m_axis_tready;
  assign mul2_rdy      = !mul2_vld_q || out_rdy;
  assign mul1_rdy      = !mul1_vld_q || mul2_rdy;
  assign off_rdy       = !off_vld_q  || mul1_rdy;
  assign s_axis_tready = off_rdy;

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, depth window, centre offsets, colour
  // ---------------------------------------------------------------------------
  logic [dptp_pkg::DEPTH_W-1:0]  in_z;
  logic [CW-1:0]                 in_row, in_col;
  logic [dptp_pkg::CHAN_W-1:0]   in_red, in_green, in_blue;
  logic [dptp_pkg::OFF_W-1:0]    pos_x, pos_y;
  logic                          in_keep;
  off_stage_t                    off_d, off_q;

  assign in_z     = s_axis_tdata[15:0];
  assign in_row   = s_axis_tdata[16 +: CW];
  assign in_col   = s_axis_tdata[26 +: CW];
  assign in_red   = s_axis_tdata[43:36];
  assign in_green = s_axis_tdata[51:44];
  assign in_blue  = s_axis_tdata[59:52];

  assign in_keep  = (in_z != '0) && (in_z <= max_depth_q);
  assign pos_x    = dptp_pkg::OFF_W'({in_col, 4'b0000});
  assign pos_y    = dptp_pkg::OFF_W'({in_row, 4'b0000});

  always_comb begin
    off_d.neg_x = pos_x < col_center_q;
    off_d.neg_y = pos_y < row_center_q;
    off_d.off_x = off_d.neg_x ? (col_center_q - pos_x) : (pos_x - col_center_q);
    off_d.off_y = off_d.neg_y ? (row_center_q - pos_y) : (pos_y - row_center_q);
    off_d.z     = in_z;
    off_d.color = color_mode_q ? {in_red, in_green, in_blue} : dptp_pkg::COLOR_WHITE;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: |offset| * Z
  // ---------------------------------------------------------------------------
  mul1_stage_t mul1_d, mul1_q;

  always_comb begin
    mul1_d.neg_x  = off_q.neg_x;
    mul1_d.neg_y  = off_q.neg_y;
    mul1_d.prod_x = dptp_pkg::PROD1_W'(off_q.off_x) * dptp_pkg::PROD1_W'(off_q.z);
    mul1_d.prod_y = dptp_pkg::PROD1_W'(off_q.off_y) * dptp_pkg::PROD1_W'(off_q.z);
    mul1_d.z      = off_q.z;
    mul1_d.color  = off_q.color;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: * reciprocal focal length
  // ---------------------------------------------------------------------------
  mul2_stage_t mul2_d, mul2_q;

  always_comb begin
    mul2_d.neg_x  = mul1_q.neg_x;
    mul2_d.neg_y  = mul1_q.neg_y;
    mul2_d.prod_x = dptp_pkg::PROD2_W'(mul1_q.prod_x) * dptp_pkg::PROD2_W'(inv_col_q);
    mul2_d.prod_y = dptp_pkg::PROD2_W'(mul1_q.prod_y) * dptp_pkg::PROD2_W'(inv_row_q);
    mul2_d.z      = mul1_q.z;
    mul2_d.color  = mul1_q.color;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round, saturate, pack into the output register
  // ---------------------------------------------------------------------------
  logic [dptp_pkg::M_TDATA_W-1:0] out_d, out_q;

  assign out_d = dptp_pkg::M_TDATA_W'({mul2_q.color, mul2_q.z,
                                       round_sat(mul2_q.prod_y, mul2_q.neg_y),
                                       round_sat(mul2_q.prod_x, mul2_q.neg_x)});

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_vld_q  <= 1'b0;
      mul1_vld_q <= 1'b0;
      mul2_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (off_rdy)  off_vld_q  <= s_axis_tvalid && in_keep;
      if (mul1_rdy) mul1_vld_q <= off_vld_q;
      if (mul2_rdy) mul2_vld_q <= mul1_vld_q;
      if (out_rdy)  out_vld_q  <= mul2_vld_q;
    end
  end

  // Advance payloads; hold them while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (off_rdy)  off_q  <= off_d;
    if (mul1_rdy) mul1_q <= mul1_d;
    if (mul2_rdy) mul2_q <= mul2_d;
    if (out_rdy)  out_q  <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== design/dptp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptp_checker
// Port-level checks on the depth pixel to point block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dptp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dptp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  // A waiting result stays offered
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)

  // A waiting result keeps its value
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))

  // Input backpressure only while a result is stuck at the output
  `ASSERT_CLK(a_in_stall_cause, clk_i, rst_ni, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))

  // A point never carries zero depth
  `ASSERT_NEVER(a_z_nonzero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[57:42] == '0))

  // Padding above the packed colour stays zero
  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[dptp_pkg::M_TDATA_W-1:dptp_pkg::M_USED_W] != '0))

endmodule

bind depth_pixel_to_point dptp_checker u_dptp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
